// ----- hw/rtl/ptwt_pkg.sv -----
// Package with shared widths, codes, types and helpers of the page table walker.
`timescale 1ns / 1ps

package ptwt_pkg;

  localparam int unsigned VaW            = 64;
  localparam int unsigned PteW           = 64;
  localparam int unsigned ShiftW         = 5;
  localparam int unsigned AddrW          = 56;
  localparam int unsigned PpnW           = 44;
  localparam int unsigned LvlW           = 3;
  localparam int unsigned IdxW           = 9;
  localparam int unsigned PageBits       = 12;
  localparam int unsigned PpnLo          = 10;
  localparam int unsigned OffW           = 32;
  localparam int unsigned FaultW         = 2;
  localparam int unsigned CfgDataW       = PpnW;
  localparam int unsigned CfgIdxW        = 1;
  localparam int unsigned PhysAddrBitsDefault = 56;

  // Input item function codes.
  localparam logic FuncTranslate = 1'b0;
  localparam logic FuncEntry     = 1'b1;

  // Result kinds.
  localparam logic KindRead = 1'b0;
  localparam logic KindDone = 1'b1;

  // Fault codes.
  localparam logic [FaultW-1:0] FaultNone     = 2'd0;
  localparam logic [FaultW-1:0] FaultEmpty    = 2'd1;
  localparam logic [FaultW-1:0] FaultNoLeaf   = 2'd2;
  localparam logic [FaultW-1:0] FaultInvalid  = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgRootPpn    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgLevelCount = 1'b1;

  localparam logic [LvlW-1:0] LevelCountMin = 3'd3;
  localparam logic [LvlW-1:0] LevelCountMax = 3'd5;
  localparam logic [LvlW-1:0] LevelTop      = 3'd4;

  typedef struct packed {
    logic [PpnW-1:0] root_ppn;
    logic [LvlW-1:0] level_count;
  } ptwt_cfg_t;

  typedef struct packed {
    logic              busy;
    logic [LvlW-1:0]   level;
    logic [VaW-1:0]    vaddr;
    logic [ShiftW-1:0] shift;
  } ptwt_walk_t;

  typedef struct packed {
    logic              kind;
    logic [AddrW-1:0]  address;
    logic [FaultW-1:0] fault;
    logic [LvlW-1:0]   level;
  } ptwt_result_t;

  // Nine-bit table index of the virtual address at a given level.
  function automatic logic [IdxW-1:0] vpn_index(logic [VaW-1:0] va, logic [LvlW-1:0] lvl);
    logic [IdxW-1:0] idx;
    case (lvl)
      3'd0: idx = va[20:12];
      3'd1: idx = va[29:21];
      3'd2: idx = va[38:30];
      3'd3: idx = va[47:39];
      3'd4: idx = va[56:48];
      default: idx = '0;
    endcase
    return idx;
  endfunction

endpackage

// ----- hw/rtl/ptwt_item_if.sv -----
// Input channel: translate requests and page table entry responses.
`timescale 1ns / 1ps

interface ptwt_item_if import ptwt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [VaW-1:0]    vaddr;
  logic [ShiftW-1:0] offset_shift;
  logic [PteW-1:0]   entry_word;

  modport source (output valid, func, vaddr, offset_shift, entry_word, input ready);
  modport sink   (input valid, func, vaddr, offset_shift, entry_word, output ready);
endinterface

// ----- hw/rtl/ptwt_result_if.sv -----
// Output channel: memory read requests and finished translations.
`timescale 1ns / 1ps

interface ptwt_result_if import ptwt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [AddrW-1:0]  address;
  logic [FaultW-1:0] fault_code;
  logic [LvlW-1:0]   leaf_level;

  modport source (output valid, kind, address, fault_code, leaf_level, input ready);
  modport sink   (input valid, kind, address, fault_code, leaf_level, output ready);
endinterface

// ----- hw/rtl/ptwt_step.sv -----
// One walk step: next walk state and the result caused by one input item.
`timescale 1ns / 1ps

module ptwt_step import ptwt_pkg::*; (
  input  ptwt_cfg_t          cfg_i,
  input  ptwt_walk_t         walk_i,
  input  logic               func_i,
  input  logic [VaW-1:0]     vaddr_i,
  input  logic [ShiftW-1:0]  offset_shift_i,
  input  logic [PteW-1:0]    entry_word_i,
  output ptwt_walk_t         walk_o,
  output logic               res_valid_o,
  output ptwt_result_t       res_o
);

  logic [PpnW-1:0] ppn;
  logic            leaf;
  logic [LvlW-1:0] lvl_cnt;
  logic [LvlW-1:0] root_lvl;
  logic [LvlW-1:0] down_lvl;
  logic [OffW-1:0] off_mask;

  assign ppn      = entry_word_i[PpnLo +: PpnW];
  assign leaf     = |entry_word_i[3:1];
  assign down_lvl = walk_i.level - 3'd1;
  assign off_mask = ~({OffW{1'b1}} << walk_i.shift);

  always_comb begin
    if (cfg_i.level_count < LevelCountMin) begin
      lvl_cnt = LevelCountMin;
    end else if (cfg_i.level_count > LevelCountMax) begin
      lvl_cnt = LevelCountMax;
    end else begin
      lvl_cnt = cfg_i.level_count;
    end
  end

  assign root_lvl = lvl_cnt - 3'd1;

  always_comb begin
    walk_o      = walk_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (func_i == FuncTranslate) begin
      // A new request drops any walk in progress.
      walk_o.busy  = 1'b1;
      walk_o.level = root_lvl;
      walk_o.vaddr = vaddr_i;
      walk_o.shift = offset_shift_i;
      res_valid_o  = 1'b1;
      res_o.kind   = KindRead;
      res_o.address = {cfg_i.root_ppn, vpn_index(vaddr_i, root_lvl), 3'b000};
      res_o.level  = root_lvl;
    end else if (walk_i.busy) begin
      res_valid_o = 1'b1;
      res_o.level = walk_i.level;
      if (leaf) begin
        walk_o.busy = 1'b0;
        res_o.kind  = KindDone;
        if (!entry_word_i[0]) begin
          res_o.fault = FaultInvalid;
        end else begin
          res_o.address = {ppn, {PageBits{1'b0}}}
                        | AddrW'(walk_i.vaddr[OffW-1:0] & off_mask);
        end
      end else if (entry_word_i == '0) begin
        walk_o.busy = 1'b0;
        res_o.kind  = KindDone;
        res_o.fault = FaultEmpty;
      end else if (walk_i.level == '0) begin
        walk_o.busy = 1'b0;
        res_o.kind  = KindDone;
        res_o.fault = FaultNoLeaf;
      end else begin
        walk_o.level  = down_lvl;
        res_o.kind    = KindRead;
        res_o.address = {ppn, vpn_index(walk_i.vaddr, down_lvl), 3'b000};
        res_o.level   = down_lvl;
      end
    end
  end

endmodule

// ----- hw/rtl/page_table_walk_translate_core.sv -----
// Page table walker top level: walk state, configuration and result register.
// A result is registered and is valid in the cycle after the transfer of the item that causes it.
// Throughput: one item per cycle; a waiting result is held in the output register and
// the next item is taken in the cycle that result is transferred.
// Entry responses that arrive with no walk in progress give no result.
// Reset: walker idle, no result pending, root page number 0, level count 3.
`timescale 1ns / 1ps

module page_table_walk_translate_core import ptwt_pkg::*; #(
  parameter int unsigned PHYS_ADDR_BITS = PhysAddrBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  ptwt_item_if.sink           item_i,
  ptwt_result_if.source       result_o
);

  ptwt_cfg_t    cfg_q;
  ptwt_walk_t   walk_q, walk_d;
  ptwt_result_t res;
  logic         res_valid;
  logic         in_fire;

  logic                      out_valid_q, out_valid_d;
  logic                      kind_q;
  logic [PHYS_ADDR_BITS-1:0] addr_q;
  logic [FaultW-1:0]         fault_q;
  logic [LvlW-1:0]           level_q;

  assign item_i.ready = !out_valid_q || result_o.ready;
  assign in_fire      = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.root_ppn    <= '0;
      cfg_q.level_count <= LevelCountMin;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgRootPpn:    cfg_q.root_ppn    <= cfg_wdata_i[PpnW-1:0];
        CfgLevelCount: cfg_q.level_count <= cfg_wdata_i[LvlW-1:0];
        default: ;
      endcase
    end
  end

  ptwt_step u_step (
    .cfg_i          (cfg_q),
    .walk_i         (walk_q),
    .func_i         (item_i.func),
    .vaddr_i        (item_i.vaddr),
    .offset_shift_i (item_i.offset_shift),
    .entry_word_i   (item_i.entry_word),
    .walk_o         (walk_d),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q.busy  <= 1'b0;
      walk_q.level <= '0;
      walk_q.vaddr <= '0;
      walk_q.shift <= 5'd12;
    end else if (in_fire) begin
      walk_q <= walk_d;
    end
  end

  always_comb begin
    if (in_fire && res_valid) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Physical addresses are cut to the implemented width here.
  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      kind_q  <= res.kind;
      addr_q  <= res.address[PHYS_ADDR_BITS-1:0];
      fault_q <= res.fault;
      level_q <= res.level;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.kind       = kind_q;
  assign result_o.address    = AddrW'(addr_q);
  assign result_o.fault_code = fault_q;
  assign result_o.leaf_level = level_q;

  a_result_from_transfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_fire))
    else $error("result appeared without an input transfer");

  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |-> !item_i.ready)
    else $error("input taken while a result is stalled");

  a_level_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_q.busy |-> (walk_q.level <= LevelTop))
    else $error("walk level out of range");

  a_done_ends_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res_valid && (res.kind == KindDone)) |=> !walk_q.busy)
    else $error("walk still busy after a finished translation");

endmodule

// ----- verif/ptwt_tb_pkg.sv -----
// Walk tracker class: shadow copy of the walker state and the queue of awaited results.
`timescale 1ns / 1ps

package ptwt_tb_pkg;
  import ptwt_pkg::*;

  class walk_tracker;
    logic [PpnW-1:0]   root_ppn;
    logic [LvlW-1:0]   level_count;
    bit                walking;
    logic [LvlW-1:0]   level;
    logic [VaW-1:0]    vaddr;
    logic [ShiftW-1:0] shift;
    ptwt_result_t      walk_results[$];
    int                errors;
    int                reads_seen;
    int                done_seen;
    int                faults_seen;

    function new();
      root_ppn    = '0;
      level_count = 3'd3;
      walking     = 1'b0;
      level       = '0;
      vaddr       = '0;
      shift       = 5'd12;
      errors      = 0;
      reads_seen  = 0;
      done_seen   = 0;
      faults_seen = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgRootPpn:    root_ppn = data[PpnW-1:0];
        CfgLevelCount: level_count = data[LvlW-1:0];
        default: ;
      endcase
    endfunction

    // Address of the entry that the saved virtual address selects in the table at ppn.
    function logic [AddrW-1:0] table_addr(logic [PpnW-1:0] ppn, logic [LvlW-1:0] lvl);
      logic [VaW-1:0] idx_bits;
      idx_bits = vaddr >> (PageBits + IdxW * lvl);
      return {ppn, {PageBits{1'b0}}} + AddrW'({idx_bits[IdxW-1:0], 3'b000});
    endfunction

    function logic [AddrW-1:0] leaf_addr(logic [PpnW-1:0] ppn);
      logic [VaW-1:0] full;
      full = {8'b0, ppn, {PageBits{1'b0}}} | (vaddr & ((64'd1 << shift) - 64'd1));
      return full[AddrW-1:0];
    endfunction

    function void await_result(logic kind, logic [AddrW-1:0] addr,
                               logic [FaultW-1:0] fault, logic [LvlW-1:0] lvl);
      ptwt_result_t r;
      r.kind    = kind;
      r.address = addr;
      r.fault   = fault;
      r.level   = lvl;
      walk_results.push_back(r);
    endfunction

    // Advances the shadow walk by one transfer; returns 0 when the block ignores it.
    function bit accept_item(logic func, logic [VaW-1:0] va, logic [ShiftW-1:0] sh,
                             logic [PteW-1:0] pte);
      logic [LvlW-1:0] lc;
      logic [PpnW-1:0] ppn;
      if (func == FuncTranslate) begin
        lc = level_count;
        if (lc < LevelCountMin) lc = LevelCountMin;
        if (lc > LevelCountMax) lc = LevelCountMax;
        vaddr   = va;
        shift   = sh;
        level   = lc - 3'd1;
        walking = 1'b1;
        await_result(KindRead, table_addr(root_ppn, level), FaultNone, level);
        return 1'b1;
      end
      if (!walking) return 1'b0;
      ppn = pte[PpnLo +: PpnW];
      // Any of R, W or X marks a leaf; bit 0 is the valid bit.
      if (pte[3:1] != 3'b000) begin
        walking = 1'b0;
        if (!pte[0]) await_result(KindDone, '0, FaultInvalid, level);
        else await_result(KindDone, leaf_addr(ppn), FaultNone, level);
      end else if (pte == '0) begin
        walking = 1'b0;
        await_result(KindDone, '0, FaultEmpty, level);
      end else if (level == '0) begin
        walking = 1'b0;
        await_result(KindDone, '0, FaultNoLeaf, '0);
      end else begin
        level = level - 3'd1;
        await_result(KindRead, table_addr(ppn, level), FaultNone, level);
      end
      return 1'b1;
    endfunction

    function void report(string what, logic [63:0] want, logic [63:0] got);
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      errors++;
    endfunction

    function void compare_result(ptwt_result_t got);
      ptwt_result_t want;
      if (walk_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, %s %0d address %h fault %0d level %0d",
                 $time, "actual kind", got.kind, got.address, got.fault, got.level);
        errors++;
        return;
      end
      want = walk_results.pop_front();
      if (got.kind != want.kind) report("kind", want.kind, got.kind);
      if (got.address != want.address) report("address", want.address, got.address);
      if (got.fault != want.fault) report("fault_code", want.fault, got.fault);
      if (got.level != want.level) report("leaf_level", want.level, got.level);
      if (got.kind == KindRead) reads_seen++;
      else done_seen++;
      if (got.fault != FaultNone) faults_seen++;
    endfunction
  endclass

endpackage

// ----- verif/page_table_walk_translate_core_tb.sv -----
// Testbench top: drives translate walks against the walker and checks every result transfer.
`timescale 1ns / 1ps

module page_table_walk_translate_core_tb import ptwt_pkg::*, ptwt_tb_pkg::*;;

  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 140;
  localparam int PhaseCount = 7;

  typedef enum {EntPointer, EntLeaf, EntBadLeaf, EntEmpty} entry_shape_e;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  bit                  allow_idle;
  int                  cycle_count;
  int                  walk_items;
  int                  settings_used;
  ptwt_result_t        seen_result;
  walk_tracker         tracker;

  ptwt_item_if   item_bus ();
  ptwt_result_if result_bus ();

  page_table_walk_translate_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_bus),
    .result_o    (result_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("%0t: timeout with %0d results outstanding", $time, tracker.walk_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  // Result side: ready high in runs, with stall bursts while idling is allowed.
  initial begin
    result_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (allow_idle && $urandom_range(0, 3) == 0) begin
        @(negedge clk);
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end else begin
        @(negedge clk);
        result_bus.ready <= 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && result_bus.valid && result_bus.ready) begin
      seen_result.kind    = result_bus.kind;
      seen_result.address = result_bus.address;
      seen_result.fault   = result_bus.fault_code;
      seen_result.level   = result_bus.leaf_level;
      tracker.compare_result(seen_result);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ShiftW-1:0] pick_shift();
    if ($urandom_range(0, 4) == 0) return ShiftW'($urandom_range(0, 31));
    return ShiftW'($urandom_range(12, 30));
  endfunction

  function automatic entry_shape_e pick_shape(logic [LvlW-1:0] lvl);
    int r;
    r = $urandom_range(0, 99);
    if (lvl != '0) begin
      if (r < 70) return EntPointer;
      if (r < 85) return EntLeaf;
      if (r < 92) return EntBadLeaf;
      return EntEmpty;
    end
    if (r < 10) return EntPointer;
    if (r < 80) return EntLeaf;
    if (r < 90) return EntBadLeaf;
    return EntEmpty;
  endfunction

  function automatic logic [PteW-1:0] make_entry(entry_shape_e shape);
    logic [PteW-1:0] pte;
    pte = rand64();
    case (shape)
      EntPointer: begin
        pte[3:1] = 3'b000;
        pte[0] = ($urandom_range(0, 7) != 0);
      end
      EntLeaf, EntBadLeaf: begin
        if (pte[3:1] == 3'b000) pte[$urandom_range(1, 3)] = 1'b1;
        pte[0] = (shape == EntLeaf);
      end
      default: pte = '0;
    endcase
    return pte;
  endfunction

  task automatic drive_item(logic func, logic [VaW-1:0] va, logic [ShiftW-1:0] sh,
                            logic [PteW-1:0] pte);
    int gap;
    if (allow_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      item_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_bus.valid        <= 1'b1;
    item_bus.func         <= func;
    item_bus.vaddr        <= va;
    item_bus.offset_shift <= sh;
    item_bus.entry_word   <= pte;
    do @(posedge clk); while (!item_bus.ready);
    if (tracker.accept_item(func, va, sh, pte)) walk_items++;
  endtask

  task automatic translate(logic [VaW-1:0] va, logic [ShiftW-1:0] sh);
    drive_item(FuncTranslate, va, sh, rand64());
  endtask

  task automatic respond(logic [PteW-1:0] pte);
    drive_item(FuncEntry, rand64(), ShiftW'($urandom_range(0, 31)), pte);
  endtask

  // Lowers valid, waits out every awaited result, then lets the pipeline drain.
  task automatic settle(int extra);
    @(negedge clk);
    item_bus.valid <= 1'b0;
    while (tracker.walk_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic program_walker(logic [CfgDataW-1:0] root, logic [CfgDataW-1:0] lc_data);
    settle(4);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgRootPpn;
    cfg_wdata <= root;
    @(posedge clk);
    tracker.write_reg(CfgRootPpn, root);
    @(negedge clk);
    cfg_idx   <= CfgLevelCount;
    cfg_wdata <= lc_data;
    @(posedge clk);
    tracker.write_reg(CfgLevelCount, lc_data);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly complete walks with random tables; a few stray responses and restarted walks.
  task automatic run_walks(int n);
    int stop_at;
    stop_at = walk_items + n;
    while (walk_items < stop_at) begin
      if ($urandom_range(0, 19) == 0) respond(rand64());
      translate(rand64(), pick_shift());
      while (tracker.walking) begin
        if ($urandom_range(0, 29) == 0) translate(rand64(), pick_shift());
        else respond(make_entry(pick_shape(tracker.level)));
      end
    end
  endtask

  initial begin
    logic [CfgDataW-1:0] root;
    logic [CfgDataW-1:0] lc_data;
    logic [LvlW-1:0]     lc_pick [PhaseCount];

    tracker               = new();
    walk_items            = 0;
    settings_used         = 1;
    allow_idle            = 1'b1;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = CfgRootPpn;
    cfg_wdata             = '0;
    item_bus.valid        = 1'b0;
    item_bus.func         = FuncTranslate;
    item_bus.vaddr        = '0;
    item_bus.offset_shift = '0;
    item_bus.entry_word   = '0;
    lc_pick = '{3'd5, 3'd4, 3'd0, 3'd7, 3'd2, 3'd6, 3'd3};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings: three levels, root page zero.
    respond('1);
    translate('1, 5'd12);
    respond(64'hFFFF_FFFF_FFFF_FFF1);
    respond(64'hFFFF_FFFF_FFFF_FFF1);
    respond('1);
    translate('1, 5'd31);
    respond(64'h3);
    translate('0, 5'd0);
    respond('0);
    translate(rand64(), 5'd12);
    respond(64'h8);
    translate(rand64(), 5'd30);
    respond(64'h401);
    respond(64'h801);
    respond(64'hC01);
    // A new request in the middle of a walk drops the old walk.
    translate(rand64(), 5'd20);
    respond(64'h401);
    translate(rand64(), 5'd16);
    respond(64'h405);
    // A pointer without its valid bit still descends.
    translate(rand64(), 5'd25);
    respond(64'h400);
    respond(64'h003F_FFFF_FFFF_FC0F);

    for (int p = 0; p < PhaseCount; p++) begin
      if (p == 0) root = '1;
      else if (p == 2) root = '0;
      else root = CfgDataW'(rand64());
      lc_data = (p % 2 == 1) ? CfgDataW'(rand64()) : '0;
      lc_data[LvlW-1:0] = (p == PhaseCount - 1) ? LvlW'($urandom_range(3, 5)) : lc_pick[p];
      allow_idle = !(p == 1 || p == PhaseCount - 1);
      program_walker(root, lc_data);
      run_walks(PhaseItems);
    end
    settle(10);

    $display("covered %0d walk transfers under %0d register settings, %0d read requests",
             walk_items, settings_used, tracker.reads_seen);
    $display("%0d translations finished, %0d results carried a fault",
             tracker.done_seen, tracker.faults_seen);
    if (tracker.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ptwt_pkg.sv
hw/rtl/ptwt_item_if.sv
hw/rtl/ptwt_result_if.sv
hw/rtl/ptwt_step.sv
hw/rtl/page_table_walk_translate_core.sv
verif/ptwt_tb_pkg.sv
verif/page_table_walk_translate_core_tb.sv
